/* hw/rtl/assert_macros.svh */
// assertion macros used by the top rtl file of the frame bit balance block
// depends on clk_i and rst_ni being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent required in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fbbrc_pkg.sv */
// shared types, widths and fixed point constants of the frame bit balance block
// no dependencies
`timescale 1ns / 1ps

package fbbrc_pkg;

  // quality format, fraction bits (sets only the reset clamps)
  localparam int unsigned QUALITY_FRAC_BITS = 16;

  // field widths
  localparam int unsigned PAY_W      = 16;
  localparam int unsigned SIDE_W     = 12;
  localparam int unsigned QUAL_W     = 32;
  localparam int unsigned BUDGET_W   = 16;
  localparam int unsigned BAL_W      = 20;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // divider: 17 bit magnitude shifted up by the ratio fraction, 16 bit divisor
  localparam int unsigned DVD_W   = 33;
  localparam int unsigned DVR_W   = 16;
  localparam int unsigned DCNT_W  = $clog2(DVD_W + 1);

  // register map
  localparam logic [1:0] REG_FRAME_BUDGET = 2'd0;
  localparam logic [1:0] REG_MIN_QUALITY  = 2'd1;
  localparam logic [1:0] REG_MAX_QUALITY  = 2'd2;

  // reset values of the registers
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd2048;
  localparam logic [63:0] MIN_Q_WIDE = 64'd10 << QUALITY_FRAC_BITS;
  localparam logic [63:0] MAX_Q_WIDE = 64'd5000 << QUALITY_FRAC_BITS;
  localparam logic [QUAL_W-1:0] MIN_Q_RESET = MIN_Q_WIDE[QUAL_W-1:0];
  localparam logic [QUAL_W-1:0] MAX_Q_RESET =
      (MAX_Q_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : MAX_Q_WIDE[QUAL_W-1:0];

  // reciprocals: floor(2^22 / 100) and floor(2^24 / 5), each with one correction
  localparam logic [15:0] RECIP_100       = 16'd41943;
  localparam int unsigned RECIP_100_SHIFT = 22;
  localparam logic [21:0] RECIP_5         = 22'd3355443;
  localparam int unsigned RECIP_5_SHIFT   = 24;

  // ratio format Q.16
  localparam int unsigned RATIO_FRAC = 16;
  localparam logic [16:0] RATIO_ONE  = 17'd65536;
  localparam logic [16:0] FIX_LOW    = 17'd52429;
  localparam logic [16:0] FIX_HIGH   = 17'd78643;
  localparam logic [16:0] FIX_SPAN   = 17'd13107;
  localparam logic [16:0] DEADBAND   = 17'd328;
  // deviation beyond this always ends at a fix clamp
  localparam logic [17:0] DEV_LIMIT  = 18'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_TGT1,
    ST_TGT2,
    ST_BAL,
    ST_NUM,
    ST_DIV,
    ST_DEV,
    ST_DMP1,
    ST_DMP2,
    ST_MUL,
    ST_OUT
  } fbbrc_state_e;

  // step enables from the controller
  typedef struct packed {
    logic load;
    logic avg;
    logic tgt1;
    logic tgt2;
    logic bal;
    logic num;
    logic div_start;
    logic dev;
    logic dmp1;
    logic dmp2;
    logic mul;
    logic out_load;
  } fbbrc_cmd_t;

  // datapath status toward the controller
  typedef struct packed {
    logic div_done;
    logic core_pos;
    logic out_free;
  } fbbrc_sts_t;

endpackage

/* hw/rtl/fbbrc_regs.sv */
// apb configuration registers: frame budget and quality clamps
// depends on fbbrc_pkg
`timescale 1ns / 1ps

module fbbrc_regs import fbbrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [BUDGET_W-1:0]   frame_budget_o,
  output logic [QUAL_W-1:0]     min_quality_o,
  output logic [QUAL_W-1:0]     max_quality_o
);

  logic [BUDGET_W-1:0] budget_q;
  logic [QUAL_W-1:0]   min_q_q;
  logic [QUAL_W-1:0]   max_q_q;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
      min_q_q  <= MIN_Q_RESET;
      max_q_q  <= MAX_Q_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_BUDGET: budget_q <= pwdata[BUDGET_W-1:0];
        REG_MIN_QUALITY:  min_q_q  <= pwdata;
        REG_MAX_QUALITY:  max_q_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_FRAME_BUDGET: prdata = {{(CFG_DATA_W-BUDGET_W){1'b0}}, budget_q};
      REG_MIN_QUALITY:  prdata = min_q_q;
      REG_MAX_QUALITY:  prdata = max_q_q;
      default:          prdata = '0;
    endcase
  end

  assign frame_budget_o = budget_q;
  assign min_quality_o  = min_q_q;
  assign max_quality_o  = max_q_q;

endmodule

/* hw/rtl/fbbrc_div.sv */
// restoring divider, one quotient bit per cycle, unsigned
// depends on fbbrc_pkg
`timescale 1ns / 1ps

module fbbrc_div import fbbrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             done_o
);

  logic [DVR_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVR_W:0]    trial;
  logic              fits;

  // one shift and subtract step
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    fits  = trial >= {1'b0, divisor_i};
    rem_d = fits ? DVR_W'(trial - {1'b0, divisor_i}) : trial[DVR_W-1:0];
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DCNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* hw/rtl/fbbrc_dp.sv */
// datapath: side average, bit balance, correction ratio, damping and quality scaling
// depends on fbbrc_pkg and fbbrc_div
`timescale 1ns / 1ps

module fbbrc_dp import fbbrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbbrc_cmd_t            cmd_i,
  output fbbrc_sts_t            sts_o,
  input  logic [PAY_W-1:0]      payload_bits_i,
  input  logic [SIDE_W-1:0]     side_bits_i,
  input  logic [QUAL_W-1:0]     quality_in_i,
  input  logic [BUDGET_W-1:0]   frame_budget_i,
  input  logic [QUAL_W-1:0]     min_quality_i,
  input  logic [QUAL_W-1:0]     max_quality_i,
  output logic [QUAL_W-1:0]     quality_out_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  // captured beat
  logic [PAY_W-1:0]  payload_q;
  logic [SIDE_W-1:0] side_q;
  logic [QUAL_W-1:0] quality_q;

  // state kept across frames
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic                    seeded_q;
  logic signed [BAL_W-1:0] balance_q, balance_d;

  // per frame intermediates
  logic [22:0]        n99_q;
  logic [38:0]        tprod_q;
  logic signed [16:0] core_target_q, core_target_d;
  logic signed [16:0] core_bits_q, core_bits_d;
  logic               far_q, far_d;
  logic               num_neg_q, num_neg_d;
  logic               dev_neg_q, dev_neg_d;
  logic [19:0]        nmag_q, nmag_d;
  logic [41:0]        dprod_q;
  logic [16:0]        fix_q, fix_d;
  logic               apply_q, apply_d;
  logic [QUAL_W:0]    qv_q, qv_d;
  logic [QUAL_W-1:0]  out_data_q, out_data_d;
  logic               out_valid_q;

  logic [DVD_W-1:0]   dividend;
  logic [DVD_W-1:0]   quotient;
  logic               div_done;
  logic               core_pos;

  // running side average, first frame seeds it
  logic [ACC_W:0] acc_sum;
  always_comb begin
    acc_sum = {1'b0, acc_q} + (ACC_W+1)'(side_q) - (ACC_W+1)'(acc_q[ACC_W-1:4]);
    acc_d   = seeded_q ? acc_sum[ACC_W-1:0] : {side_q, 4'b0000};
  end

  // core target: floor(budget * 99 / 100) minus the side charge
  logic [16:0] q100;
  logic [23:0] hund;
  logic [23:0] rem100;
  logic [16:0] b99;
  always_comb begin
    q100          = tprod_q[RECIP_100_SHIFT +: 17];
    hund          = 24'(q100) * 24'd100;
    rem100        = 24'(n99_q) - hund;
    b99           = q100 + 17'(rem100 >= 24'd100);
    core_target_d = $signed({1'b0, b99[15:0]}) - $signed({5'b00000, acc_q[ACC_W-1:4]});
    core_bits_d   = $signed({1'b0, payload_q}) - $signed({5'b00000, side_q});
  end

  // balance update with saturation at four budgets
  logic signed [21:0] bal_sum;
  logic signed [21:0] bound22;
  always_comb begin
    bound22 = $signed({4'b0000, frame_budget_i, 2'b00});
    bal_sum = 22'(balance_q) + 22'(core_target_q) - 22'(core_bits_q);
    if (bal_sum > bound22) begin
      balance_d = BAL_W'(bound22);
    end else if (bal_sum < -bound22) begin
      balance_d = BAL_W'(-bound22);
    end else begin
      balance_d = BAL_W'(bal_sum);
    end
  end

  // numerator: target plus balance / 32 toward zero, and the damping select
  logic [BAL_W-1:0]        bal_abs;
  logic [14:0]             lend_mag;
  logic signed [19:0]      lend_s;
  logic signed [19:0]      num_s;
  logic [19:0]             num_abs;
  logic signed [20:0]      bal2;
  logic signed [20:0]      bound21;
  always_comb begin
    bal_abs   = balance_q[BAL_W-1] ? -balance_q : balance_q;
    lend_mag  = bal_abs[BAL_W-1:5];
    lend_s    = balance_q[BAL_W-1] ? -$signed({5'b00000, lend_mag})
                                   : $signed({5'b00000, lend_mag});
    num_s     = 20'(core_target_q) + lend_s;
    num_neg_d = num_s[19];
    num_abs   = num_s[19] ? -num_s : num_s;
    dividend  = {num_abs[16:0], {RATIO_FRAC{1'b0}}};
    bal2      = $signed({balance_q, 1'b0});
    bound21   = $signed({3'b000, frame_budget_i, 2'b00});
    far_d     = (bal2 > bound21) || (bal2 < -bound21);
  end

  assign core_pos = !core_bits_q[16] && (core_bits_q != '0);

  fbbrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (core_bits_q[DVR_W-1:0]),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // deviation from one, saturated, then scaled by 3 or by 17/4
  logic signed [34:0] ratio_w;
  logic signed [34:0] dev_w;
  logic [17:0]        dev_abs;
  logic [19:0]        n3;
  logic [21:0]        n17;
  always_comb begin
    ratio_w = num_neg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    dev_w   = ratio_w - $signed({18'd0, RATIO_ONE});
    if (!core_pos) begin
      dev_neg_d = 1'b0;
      dev_abs   = '0;
    end else if (dev_w > $signed({17'd0, DEV_LIMIT})) begin
      dev_neg_d = 1'b0;
      dev_abs   = DEV_LIMIT;
    end else if (dev_w < -$signed({17'd0, DEV_LIMIT})) begin
      dev_neg_d = 1'b1;
      dev_abs   = DEV_LIMIT;
    end else begin
      dev_neg_d = dev_w[34];
      dev_abs   = dev_w[34] ? 18'(-dev_w) : 18'(dev_w);
    end
    n3     = {2'b00, dev_abs} + {1'b0, dev_abs, 1'b0};
    n17    = {dev_abs, 4'b0000} + {4'b0000, dev_abs};
    nmag_d = far_q ? n17[21:2] : n3;
  end

  // divide by five, deadband and clamp of the fix factor
  logic [17:0] q5;
  logic [20:0] five;
  logic [20:0] rem5;
  logic [17:0] dmag;
  logic [17:0] fix_w;
  always_comb begin
    q5    = dprod_q[RECIP_5_SHIFT +: 18];
    five  = 21'(q5) * 21'd5;
    rem5  = 21'(nmag_q) - five;
    dmag  = q5 + 18'(rem5 >= 21'd5);
    if (dmag > 18'(FIX_SPAN)) begin
      fix_w = dev_neg_q ? 18'(FIX_LOW) : 18'(FIX_HIGH);
    end else if (dev_neg_q) begin
      fix_w = 18'(RATIO_ONE) - dmag;
    end else begin
      fix_w = 18'(RATIO_ONE) + dmag;
    end
    fix_d   = fix_w[16:0];
    apply_d = dmag > 18'(DEADBAND);
  end

  // quality scaling
  logic [48:0] qprod;
  always_comb begin
    qprod = 49'(quality_q) * 49'(fix_q);
    qv_d  = apply_q ? qprod[48:RATIO_FRAC] : {1'b0, quality_q};
  end

  // upper clamp first, lower clamp wins
  logic [QUAL_W-1:0] q_hi;
  always_comb begin
    q_hi       = (qv_q > {1'b0, max_quality_i}) ? max_quality_i : qv_q[QUAL_W-1:0];
    out_data_d = (q_hi < min_quality_i) ? min_quality_i : q_hi;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      seeded_q  <= 1'b0;
      balance_q <= '0;
    end else begin
      if (cmd_i.avg) begin
        acc_q    <= acc_d;
        seeded_q <= 1'b1;
      end
      if (cmd_i.bal) begin
        balance_q <= balance_d;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // step registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      payload_q <= payload_bits_i;
      side_q    <= side_bits_i;
      quality_q <= quality_in_i;
    end
    if (cmd_i.avg) begin
      n99_q <= 23'(frame_budget_i) * 23'd99;
    end
    if (cmd_i.tgt1) begin
      tprod_q <= 39'(n99_q) * 39'(RECIP_100);
    end
    if (cmd_i.tgt2) begin
      core_target_q <= core_target_d;
      core_bits_q   <= core_bits_d;
    end
    if (cmd_i.num) begin
      num_neg_q <= num_neg_d;
      far_q     <= far_d;
    end
    if (cmd_i.dev) begin
      dev_neg_q <= dev_neg_d;
      nmag_q    <= nmag_d;
    end
    if (cmd_i.dmp1) begin
      dprod_q <= 42'(nmag_q) * 42'(RECIP_5);
    end
    if (cmd_i.dmp2) begin
      fix_q   <= fix_d;
      apply_q <= apply_d;
    end
    if (cmd_i.mul) begin
      qv_q <= qv_d;
    end
    if (cmd_i.out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.core_pos = core_pos;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign quality_out_o = out_data_q;
  assign out_valid_o   = out_valid_q;

endmodule

/* hw/rtl/fbbrc_ctrl.sv */
// controller: sequences the datapath steps of one frame
// depends on fbbrc_pkg
`timescale 1ns / 1ps

module fbbrc_ctrl import fbbrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output fbbrc_cmd_t cmd_o,
  input  fbbrc_sts_t sts_i
);

  fbbrc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_AVG;
      ST_AVG:  state_d = ST_TGT1;
      ST_TGT1: state_d = ST_TGT2;
      ST_TGT2: state_d = ST_BAL;
      ST_BAL:  state_d = ST_NUM;
      ST_NUM:  state_d = sts_i.core_pos ? ST_DIV : ST_DEV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_DEV;
      ST_DEV:  state_d = ST_DMP1;
      ST_DMP1: state_d = ST_DMP2;
      ST_DMP2: state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // step enables
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_AVG:  cmd_o.avg  = 1'b1;
      ST_TGT1: cmd_o.tgt1 = 1'b1;
      ST_TGT2: cmd_o.tgt2 = 1'b1;
      ST_BAL:  cmd_o.bal  = 1'b1;
      ST_NUM: begin
        cmd_o.num       = 1'b1;
        cmd_o.div_start = sts_i.core_pos;
      end
      ST_DIV:  ;
      ST_DEV:  cmd_o.dev  = 1'b1;
      ST_DMP1: cmd_o.dmp1 = 1'b1;
      ST_DMP2: cmd_o.dmp2 = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/frame_bit_balance_rate_control.sv */
// Frame bit balance rate control: one input beat per coded frame gives one
// output beat with the new quality. The correction ratio is formed by the 33
// step restoring divider; a frame whose core bit count is zero or negative
// skips the divider. The next frame is accepted as soon as the result has
// moved into the output register. The user must write the registers over APB
// only while no frame is in flight; the block itself does not enforce this.
// Quality values are unsigned Q16.16.
// depends on fbbrc_pkg, fbbrc_regs, fbbrc_ctrl, fbbrc_dp, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_bit_balance_rate_control import fbbrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // frame beat in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // payload_bits [15:0], side_bits [27:16], quality_in [59:28], zero [63:60]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // quality beat out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // quality_out [31:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  fbbrc_cmd_t          cmd;
  fbbrc_sts_t          sts;
  logic [BUDGET_W-1:0] frame_budget;
  logic [QUAL_W-1:0]   min_quality;
  logic [QUAL_W-1:0]   max_quality;

  fbbrc_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_budget_o (frame_budget),
    .min_quality_o  (min_quality),
    .max_quality_o  (max_quality)
  );

  fbbrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fbbrc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .payload_bits_i (s_axis_tdata[15:0]),
    .side_bits_i    (s_axis_tdata[27:16]),
    .quality_in_i   (s_axis_tdata[59:28]),
    .frame_budget_i (frame_budget),
    .min_quality_i  (min_quality),
    .max_quality_i  (max_quality),
    .quality_out_o  (m_axis_tdata),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready)
  );

  // one frame in flight at a time
  `ASSERT_NEXT(a_single_frame, s_axis_tvalid && s_axis_tready, !s_axis_tready, "frame accepted while busy")
  // the output register is never overwritten while it holds an untaken beat
  `ASSERT_HOLDS(a_load_free, cmd.out_load |-> (!m_axis_tvalid || m_axis_tready), "output beat overwritten")
  // a loaded result is offered on the next cycle
  `ASSERT_NEXT(a_load_shows, cmd.out_load, m_axis_tvalid, "loaded result not offered")
  // the divider only runs with a positive divisor
  `ASSERT_HOLDS(a_div_pos, cmd.div_start |-> sts.core_pos, "divider started on empty core")

endmodule
